@@ sv/srogu_pkg.sv @@
// Shared types, constants and constant tables for the sonar ray occupancy grid update core.
// No dependencies; every other file of the block but srogu_ram imports this package.
package srogu_pkg;

   localparam int GRID_SIDE        = 256;
   localparam int RAYS_PER_RETURN  = 8;
   localparam int SINE_TABLE_DEPTH = 1024;

   localparam int GRID_BITS = $clog2(GRID_SIDE);
   localparam int ADDR_W    = 2 * GRID_BITS;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int RAY_BITS  = $clog2(RAYS_PER_RETURN + 1);
   localparam int QUARTER   = SINE_TABLE_DEPTH / 4;
   localparam int QBITS     = $clog2(QUARTER);
   localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);

   // angles in sixteenths of a degree
   localparam int TURN16         = 5760;
   localparam int QUARTER_TURN16 = 1440;
   localparam int ANGLE_W        = 13;
   localparam int ANGLE_SUM_W    = 15;

   // table index = floor(angle * depth / turn), by reciprocal
   localparam int     IDX_SHIFT  = 32;
   localparam int     IDX_MULT_W = 33;
   localparam longint IDX_MULT   =
      ((longint'(SINE_TABLE_DEPTH) << IDX_SHIFT) + TURN16 - 1) / TURN16;

   // floor(n / 25) = (n * DIV25_MULT) >> 32 for n below 2^30
   localparam int     DIV25_SHIFT  = 32;
   localparam int     DIV25_MULT_W = 28;
   localparam longint DIV25_MULT   = 171798692;
   localparam int     DIVIDEND_W   = 27;
   localparam int     QUOT_W       = 23;

   localparam int SIN_W      = 16;
   localparam int SIN_MAG_W  = 15;
   localparam int RQ_W       = 24;
   localparam int I_W        = 24;
   localparam int MAG_W      = 23;
   localparam int OFFQ_W     = 18;
   localparam int OFF_W      = 40;
   localparam int COORD_W    = 44;
   localparam int COORD_FRAC = 22;
   localparam int FRAC_W     = 20;
   localparam int COUNT_W    = 16;

   localparam longint CENTRE_Q22 =
      (longint'(GRID_SIDE / 2) << COORD_FRAC) - (longint'(1) << (COORD_FRAC - 1));

   // register indexes of the configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXELS_PER_METER = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_GAIN         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISS_LOSS        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_HIT_CELLS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HIT_CELLS    = 3'd4;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // quarter-wave odd polynomial, Q30 in, Q14 out
   function automatic longint quarter_sine(longint x);
      longint x2, t, s;
      x2 = (x * x) >>> 30;
      t  = 64'sd85569278 - ((x2 * 64'sd5026937) >>> 30);
      t  = 64'sd693598712 - ((x2 * t) >>> 30);
      t  = 64'sd1686629713 - ((x2 * t) >>> 30);
      s  = (x * t) >>> 30;
      s  = (s + 32768) >>> 16;
      if (s > 16384) s = 16384;
      return s;
   endfunction

   typedef logic [SIN_MAG_W-1:0] sine_mag_type;
   typedef sine_mag_type quarter_lut_type [QUARTER];

   function automatic quarter_lut_type build_quarter_lut();
      quarter_lut_type lut;
      for (int j = 0; j < QUARTER; j++) begin
         lut[j] = sine_mag_type'(quarter_sine(longint'(j) << (30 - QBITS)));
      end
      return lut;
   endfunction

   localparam quarter_lut_type QUARTER_LUT = build_quarter_lut();
   localparam sine_mag_type    QUARTER_TOP = sine_mag_type'(quarter_sine(longint'(1) << 30));

   // floor(r * 2^20 / 25) for a remainder r below 25
   typedef logic [FRAC_W-1:0] frac_type;
   typedef frac_type frac_lut_type [32];

   function automatic frac_lut_type build_frac_lut();
      frac_lut_type lut;
      for (int r = 0; r < 32; r++) begin
         lut[r] = (r < 25) ? frac_type'((longint'(r) << FRAC_W) / 25) : '0;
      end
      return lut;
   endfunction

   localparam frac_lut_type FRAC25_LUT = build_frac_lut();

   // full-wave sine from the quarter table, Q14
   function automatic logic signed [SIN_W-1:0] sine_lookup(logic [IDX_BITS-1:0] idx);
      logic [QBITS-1:0]     m;
      logic [QBITS-1:0]     m_ref;
      logic [SIN_MAG_W-1:0] mag;
      m     = idx[QBITS-1:0];
      m_ref = ~m + 1'b1;
      if (idx[QBITS]) begin
         mag = (m == '0) ? QUARTER_TOP : QUARTER_LUT[m_ref];
      end else begin
         mag = QUARTER_LUT[m];
      end
      return idx[QBITS+1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   typedef struct packed {
      logic              kind;
      logic [12:0]       bearing_sixteenth_deg;
      logic [12:0]       heading_sixteenth_deg;
      logic [14:0]       range_cm;
      logic [9:0]        step_q8;
      logic signed [15:0] pos_x_cm;
      logic signed [15:0] pos_y_cm;
      logic [7:0]        read_col;
      logic [7:0]        read_row;
   } req_item_type;

   typedef struct packed {
      logic               kind_echo;
      logic [7:0]         cell_value;
      logic [COUNT_W-1:0] cells_touched;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0] pixels_per_meter;
      logic [7:0] hit_gain;
      logic [7:0] miss_loss;
      logic [9:0] min_hit_cells;
      logic [9:0] max_hit_cells;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_PRE, ST_DIV_R, ST_DIV_X, ST_DIV_Y, ST_OFF,
      ST_ANG, ST_IDX, ST_LUT, ST_MUL, ST_ADD, ST_RD, ST_WR, ST_CELL_RD, ST_DONE
   } state_type;

   typedef enum logic [1:0] {DIV_RANGE, DIV_POS_X, DIV_POS_Y} div_sel_type;

   typedef struct packed {
      logic        clear_en;
      logic        load_item;
      logic        pre_en;
      logic        div_en;
      div_sel_type div_sel;
      logic        off_en;
      logic        ang_en;
      logic        idx_en;
      logic        ray_start;
      logic        mul_en;
      logic        add_en;
      logic        walk_rd;
      logic        walk_wr;
      logic        walk_step;
      logic        ray_next;
      logic        cell_rd;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic in_bounds;
      logic walk_last;
      logic ray_last;
      logic rsp_busy;
   } status_type;

endpackage

@@ sv/sonar_ray_occupancy_grid_update_core.sv @@
// Sonar ray occupancy grid update core: top level with stream ports and config registers.
// Update beat: setup, then for each of the 8 rays an angle and sine lookup and a walk
// that reads, updates and writes back one cell at a time on in-grid steps and skips
// off-grid ones; read beat: one read through the map RAM. A stalled reply adds its wait
// to the next reply only. One beat in work at a time; the next request is taken while a
// reply waits. Reset (synchronous) restores register defaults and runs a clearing pass
// over the map, one cell a cycle, with req_tready low; config writes are taken.
module sonar_ray_occupancy_grid_update_core (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // from bit 0: bearing_sixteenth_deg[13], heading_sixteenth_deg[13], range_cm[15],
   // step_q8[10], pos_x_cm[16], pos_y_cm[16], read_col[8], read_row[8], zero pad[5]
   input  logic [103:0]                       req_tdata,
   // from bit 0: kind
   input  logic                               req_tuser,
   // reply stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // from bit 0: cell_value[8], cells_touched[16]
   output logic [23:0]                        rsp_tdata,
   // from bit 0: kind_echo
   output logic                               rsp_tuser,
   // config write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [srogu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [srogu_pkg::CSR_DATA_W-1:0]   csr_data
);
   import srogu_pkg::*;

   cfg_type      cfg_ff;
   req_item_type req_item;
   rsp_item_type rsp_item;
   cmd_type      cmd;
   status_type   status;

   // Config registers: always ready, unknown indexes drop silently.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixels_per_meter <= 7'd4;
         cfg_ff.hit_gain         <= 8'd119;
         cfg_ff.miss_loss        <= 8'd17;
         cfg_ff.min_hit_cells    <= 10'd10;
         cfg_ff.max_hit_cells    <= 10'd200;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PIXELS_PER_METER: cfg_ff.pixels_per_meter <= csr_data[6:0];
            CSR_HIT_GAIN:         cfg_ff.hit_gain         <= csr_data[7:0];
            CSR_MISS_LOSS:        cfg_ff.miss_loss        <= csr_data[7:0];
            CSR_MIN_HIT_CELLS:    cfg_ff.min_hit_cells    <= csr_data;
            CSR_MAX_HIT_CELLS:    cfg_ff.max_hit_cells    <= csr_data;
            default: ;
         endcase
      end
   end

   // Unpack the request beat.
   assign req_item.kind                  = req_tuser;
   assign req_item.bearing_sixteenth_deg = req_tdata[12:0];
   assign req_item.heading_sixteenth_deg = req_tdata[25:13];
   assign req_item.range_cm              = req_tdata[40:26];
   assign req_item.step_q8               = req_tdata[50:41];
   assign req_item.pos_x_cm              = req_tdata[66:51];
   assign req_item.pos_y_cm              = req_tdata[82:67];
   assign req_item.read_col              = req_tdata[90:83];
   assign req_item.read_row              = req_tdata[98:91];

   // Sequencer: walks the setup, ray and step phases.
   srogu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: holds the map RAM and the reply register.
   srogu_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .req_item   (req_item),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the reply beat.
   assign rsp_tdata = {rsp_item.cells_touched, rsp_item.cell_value};
   assign rsp_tuser = rsp_item.kind_echo;

endmodule

@@ sv/srogu_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module srogu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/srogu_ctrl.sv @@
// Sequencer for the occupancy grid update: clear pass, setup, ray and walk loop, reply.
// Depends on srogu_pkg; drives srogu_dp through the command struct.
module srogu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_kind,
   input  srogu_pkg::status_type status,
   output srogu_pkg::cmd_type    cmd
);
   import srogu_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.div_sel = DIV_RANGE;
      req_tready = 1'b0;
      unique case (state_ff) inside
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in = (req_kind == KIND_READ) ? ST_CELL_RD : ST_PRE;
            end
         end
         ST_PRE: begin
            cmd.pre_en = 1'b1;
            state_in   = ST_DIV_R;
         end
         ST_DIV_R: begin
            cmd.div_en  = 1'b1;
            cmd.div_sel = DIV_RANGE;
            state_in    = ST_DIV_X;
         end
         ST_DIV_X: begin
            cmd.div_en  = 1'b1;
            cmd.div_sel = DIV_POS_X;
            state_in    = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            cmd.div_en  = 1'b1;
            cmd.div_sel = DIV_POS_Y;
            state_in    = ST_OFF;
         end
         ST_OFF: begin
            cmd.off_en = 1'b1;
            state_in   = ST_ANG;
         end
         ST_ANG: begin
            cmd.ang_en = 1'b1;
            state_in   = ST_IDX;
         end
         ST_IDX: begin
            cmd.idx_en = 1'b1;
            state_in   = ST_LUT;
         end
         ST_LUT: begin
            cmd.ray_start = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = ST_RD;
         end
         ST_RD, ST_WR: begin
            if (state_ff == ST_RD && status.in_bounds) begin
               cmd.walk_rd = 1'b1;
               state_in    = ST_WR;
            end else begin
               cmd.walk_wr   = (state_ff == ST_WR);
               cmd.walk_step = 1'b1;
               if (!status.walk_last) begin
                  state_in = ST_MUL;
               end else if (status.ray_last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.ray_next = 1'b1;
                  state_in     = ST_ANG;
               end
            end
         end
         ST_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

@@ sv/srogu_dp.sv @@
// Datapath of the occupancy grid update: scaling, angle and sine lookup, ray walk,
// cell read-modify-write and the reply register. Depends on srogu_pkg and srogu_ram.
module srogu_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  srogu_pkg::cmd_type      cmd,
   input  srogu_pkg::cfg_type      cfg,
   input  srogu_pkg::req_item_type req_item,
   output srogu_pkg::status_type   status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output srogu_pkg::rsp_item_type rsp_item
);
   import srogu_pkg::*;

   localparam logic [DIV25_MULT_W-1:0] M25   = DIV25_MULT_W'(DIV25_MULT);
   localparam logic [IDX_MULT_W-1:0]   MIDX  = IDX_MULT_W'(IDX_MULT);
   localparam logic signed [COORD_W-1:0] CENTRE = COORD_W'(CENTRE_Q22);
   localparam logic signed [COORD_W-1:0] NEG_LIMIT = COORD_W'(-(longint'(1) << COORD_FRAC));

   // reduce a positive angle sum below four turns to one turn
   function automatic logic [ANGLE_W-1:0] reduce_angle(logic [ANGLE_SUM_W-1:0] s);
      logic [ANGLE_SUM_W-1:0] r;
      if (s >= ANGLE_SUM_W'(3 * TURN16))      r = s - ANGLE_SUM_W'(3 * TURN16);
      else if (s >= ANGLE_SUM_W'(2 * TURN16)) r = s - ANGLE_SUM_W'(2 * TURN16);
      else if (s >= ANGLE_SUM_W'(TURN16))     r = s - ANGLE_SUM_W'(TURN16);
      else                                    r = s;
      return r[ANGLE_W-1:0];
   endfunction

   // Q22 coordinate to cell, truncating toward zero; top bit is the in-grid flag
   function automatic logic [GRID_BITS:0] to_cell(logic signed [COORD_W-1:0] v);
      logic signed [COORD_W-COORD_FRAC-1:0] hi;
      logic                                 ok;
      logic [GRID_BITS-1:0]                 c;
      hi = v[COORD_W-1:COORD_FRAC];
      ok = 1'b0;
      c  = '0;
      if (v > NEG_LIMIT) begin
         if (v < 0) begin
            ok = 1'b1;
         end else if (hi < GRID_SIDE) begin
            ok = 1'b1;
            c  = hi[GRID_BITS-1:0];
         end
      end
      return {ok, c};
   endfunction

   // item
   req_item_type item_ff;
   logic [9:0]   step_ff;
   logic         cell_ok_ff;

   // setup
   logic [21:0]        prod_r_ff;
   logic [MAG_W-1:0]   mag_x_ff, mag_y_ff;
   logic [RQ_W-1:0]    rq8_ff;
   logic [OFFQ_W-1:0]  q_x_ff, q_y_ff;
   logic signed [OFF_W-1:0] off_x_ff, off_y_ff;
   logic               hit_ok_ff;

   // ray
   logic [RAY_BITS-1:0] ray_ff;
   logic [ANGLE_W-1:0]  a_sin_ff, a_cos_ff;
   logic [IDX_BITS-1:0] idx_sin_ff, idx_cos_ff;
   logic signed [SIN_W-1:0] sn_ff, cs_ff;
   logic [I_W-1:0]      i_ff;

   // walk
   logic signed [SIN_W+I_W:0] pc_ff, ps_ff;
   logic [GRID_BITS-1:0] cx_ff, cy_ff;
   logic                 in_bounds_ff;
   logic                 hit_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [ADDR_W-1:0]    clr_ff;

   // reply
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;

   // combinational
   logic [DIVIDEND_W-1:0]              dividend;
   logic [DIVIDEND_W+DIV25_MULT_W-1:0] dprod;
   logic [QUOT_W-1:0]                  quot;
   logic [MAG_W-1:0]                   rem_x, rem_y;
   logic [OFF_W-1:0]                   omag_x, omag_y;
   logic [ANGLE_SUM_W-1:0]             ang_sum;
   logic [ANGLE_W-1:0]                 a_sin, a_cos_sum;
   logic [ANGLE_W+IDX_MULT_W-1:0]      iprod_sin, iprod_cos;
   logic signed [COORD_W-1:0]          vx, vy;
   logic [GRID_BITS:0]                 cell_x, cell_y;
   logic [7:0]                         rd_data;
   logic [8:0]                         gain_sum;
   logic [7:0]                         new_value;
   logic                               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]                  ram_wr_addr, ram_rd_addr, cell_addr;
   logic [7:0]                         ram_wr_data;

   always_comb begin
      case (cmd.div_sel)
         DIV_RANGE: dividend = {prod_r_ff, 5'b00000};
         DIV_POS_X: dividend = DIVIDEND_W'(mag_x_ff);
         DIV_POS_Y: dividend = DIVIDEND_W'(mag_y_ff);
         default:   dividend = '0;
      endcase
      dprod = dividend * M25;
      quot  = dprod[DIV25_SHIFT +: QUOT_W];

      rem_x  = mag_x_ff - MAG_W'(q_x_ff) * MAG_W'(25);
      rem_y  = mag_y_ff - MAG_W'(q_y_ff) * MAG_W'(25);
      omag_x = {OFF_W'(q_x_ff) << FRAC_W} + OFF_W'(FRAC25_LUT[rem_x[4:0]]);
      omag_y = {OFF_W'(q_y_ff) << FRAC_W} + OFF_W'(FRAC25_LUT[rem_y[4:0]]);

      ang_sum = ANGLE_SUM_W'(item_ff.heading_sixteenth_deg)
              - ANGLE_SUM_W'(item_ff.bearing_sixteenth_deg)
              + ANGLE_SUM_W'(32 + 2 * TURN16)
              - (ANGLE_SUM_W'(ray_ff) << 3);
      a_sin     = reduce_angle(ang_sum);
      a_cos_sum = a_sin + ANGLE_W'(QUARTER_TURN16);

      iprod_sin = a_sin_ff * MIDX;
      iprod_cos = a_cos_ff * MIDX;

      vx     = COORD_W'(pc_ff) + CENTRE + COORD_W'(off_x_ff);
      vy     = COORD_W'(ps_ff) + CENTRE - COORD_W'(off_y_ff);
      cell_x = to_cell(vx);
      cell_y = to_cell(vy);

      gain_sum = {1'b0, rd_data} + {1'b0, cfg.hit_gain};
      if (hit_ff) begin
         new_value = gain_sum[8] ? 8'hFF : gain_sum[7:0];
      end else begin
         new_value = (rd_data > cfg.miss_loss) ? rd_data - cfg.miss_loss : 8'h00;
      end

      cell_addr   = {GRID_BITS'(item_ff.read_row), GRID_BITS'(item_ff.read_col)};
      ram_wr_en   = cmd.clear_en | cmd.walk_wr;
      ram_wr_addr = cmd.clear_en ? clr_ff : {cy_ff, cx_ff};
      ram_wr_data = cmd.clear_en ? 8'h00 : new_value;
      ram_rd_en   = cmd.walk_rd | cmd.cell_rd;
      ram_rd_addr = cmd.cell_rd ? cell_addr : {cy_ff, cx_ff};
   end

   srogu_ram #(.WIDTH(8), .DEPTH(CELLS)) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_en) clr_ff <= clr_ff + 1'b1;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff    <= req_item;
         step_ff    <= (req_item.step_q8 == '0) ? 10'd1 : req_item.step_q8;
         cell_ok_ff <= (32'(req_item.read_col) < GRID_SIDE) &&
                       (32'(req_item.read_row) < GRID_SIDE);
         ray_ff     <= '0;
         count_ff   <= '0;
      end
      if (cmd.pre_en) begin
         prod_r_ff <= item_ff.range_cm * cfg.pixels_per_meter;
         mag_x_ff  <= MAG_W'(item_ff.pos_x_cm[15] ? 17'(-$signed(17'(item_ff.pos_x_cm)))
                                                  : 17'(item_ff.pos_x_cm))
                      * MAG_W'(cfg.pixels_per_meter);
         mag_y_ff  <= MAG_W'(item_ff.pos_y_cm[15] ? 17'(-$signed(17'(item_ff.pos_y_cm)))
                                                  : 17'(item_ff.pos_y_cm))
                      * MAG_W'(cfg.pixels_per_meter);
      end
      if (cmd.div_en) begin
         case (cmd.div_sel)
            DIV_RANGE: rq8_ff <= RQ_W'(quot);
            DIV_POS_X: q_x_ff <= quot[OFFQ_W-1:0];
            DIV_POS_Y: q_y_ff <= quot[OFFQ_W-1:0];
            default: ;
         endcase
      end
      if (cmd.off_en) begin
         off_x_ff  <= item_ff.pos_x_cm[15] ? -$signed(omag_x) : $signed(omag_x);
         off_y_ff  <= item_ff.pos_y_cm[15] ? -$signed(omag_y) : $signed(omag_y);
         hit_ok_ff <= (rq8_ff > RQ_W'({cfg.min_hit_cells, 8'h00})) &&
                      (rq8_ff < RQ_W'({cfg.max_hit_cells, 8'h00}));
      end
      if (cmd.ang_en) begin
         a_sin_ff <= a_sin;
         a_cos_ff <= (a_cos_sum >= ANGLE_W'(TURN16)) ? a_cos_sum - ANGLE_W'(TURN16)
                                                     : a_cos_sum;
      end
      if (cmd.idx_en) begin
         idx_sin_ff <= iprod_sin[IDX_SHIFT +: IDX_BITS];
         idx_cos_ff <= iprod_cos[IDX_SHIFT +: IDX_BITS];
      end
      if (cmd.ray_start) begin
         sn_ff <= sine_lookup(idx_sin_ff);
         cs_ff <= sine_lookup(idx_cos_ff);
         i_ff  <= rq8_ff + I_W'(step_ff);
      end
      if (cmd.mul_en) begin
         pc_ff <= cs_ff * $signed({1'b0, i_ff});
         ps_ff <= sn_ff * $signed({1'b0, i_ff});
      end
      if (cmd.add_en) begin
         cx_ff        <= cell_x[GRID_BITS-1:0];
         cy_ff        <= cell_y[GRID_BITS-1:0];
         in_bounds_ff <= cell_x[GRID_BITS] & cell_y[GRID_BITS];
         hit_ff       <= (i_ff == rq8_ff) && hit_ok_ff;
      end
      if (cmd.walk_wr && count_ff != '1) begin
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.walk_step) begin
         i_ff <= i_ff - I_W'(step_ff);
      end
      if (cmd.ray_next) begin
         ray_ff <= ray_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_ff.kind_echo     <= item_ff.kind;
         rsp_ff.cell_value    <= (item_ff.kind == KIND_READ && cell_ok_ff) ? rd_data : 8'h00;
         rsp_ff.cells_touched <= (item_ff.kind == KIND_READ) ? '0 : count_ff;
      end
   end

   assign status.clear_last = &clr_ff;
   assign status.in_bounds  = in_bounds_ff;
   assign status.walk_last  = i_ff <= I_W'(step_ff);
   assign status.ray_last   = ray_ff == RAY_BITS'(RAYS_PER_RETURN - 1);
   assign status.rsp_busy   = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule
